[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; all check on clk with arst_n low as
// the disable condition.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of clk
`define ASSERT_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// implication whose consequent is checked on the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[hw/rtl/sfb_pkg.sv]
// ----------------------------------------------------------------------------
// sfb_pkg
// Types and constants of the stuffed frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic       seq_bit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_run;
	} out_item_t;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] esc_char;
		logic [7:0] escaped_flag_code;
		logic [7:0] escaped_escape_code;
		logic [7:0] address_byte;
		logic [7:0] control_seq_zero;
		logic [7:0] control_seq_one;
	} cfg_t;

	// one classified request handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
		logic       seq_bit;
		logic       data_is_flag;
		logic       data_is_esc;
		logic [7:0] bcc;
		logic       bcc_is_flag;
		logic       bcc_is_esc;
	} job_t;

	typedef struct packed {
		logic emit;
		logic mid_job;
	} bk_status_t;

	typedef enum logic [2:0] {
		REG_FLAG     = 3'd0,
		REG_ESC      = 3'd1,
		REG_ESC_FLAG = 3'd2,
		REG_ESC_ESC  = 3'd3,
		REG_ADDR     = 3'd4,
		REG_CTRL0    = 3'd5,
		REG_CTRL1    = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_START,
		ST_FLAG_OPEN,
		ST_ADDR,
		ST_CTRL,
		ST_HCS,
		ST_DATA,
		ST_DATA_CODE,
		ST_BCC,
		ST_BCC_CODE,
		ST_FLAG_CLOSE
	} step_t;

	localparam logic [7:0] RST_FLAG     = 8'd126;
	localparam logic [7:0] RST_ESC      = 8'd125;
	localparam logic [7:0] RST_ESC_FLAG = 8'd94;
	localparam logic [7:0] RST_ESC_ESC  = 8'd93;
	localparam logic [7:0] RST_ADDR     = 8'd3;
	localparam logic [7:0] RST_CTRL0    = 8'd0;
	localparam logic [7:0] RST_CTRL1    = 8'd64;

endpackage

[hw/rtl/sfb_regs.sv]
// ----------------------------------------------------------------------------
// sfb_regs
// APB configuration registers: delimiters, escape codes, header bytes.
// ----------------------------------------------------------------------------
module sfb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfb_pkg::ADDR_W-1:0] paddr,
	input  logic [sfb_pkg::DATA_W-1:0] pwdata,
	output logic [sfb_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output sfb_pkg::cfg_t              cfg
);
	import sfb_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	reg_idx_t   idx;
	logic [7:0] rd_byte;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte           <= RST_FLAG;
			cfg_q.esc_char            <= RST_ESC;
			cfg_q.escaped_flag_code   <= RST_ESC_FLAG;
			cfg_q.escaped_escape_code <= RST_ESC_ESC;
			cfg_q.address_byte        <= RST_ADDR;
			cfg_q.control_seq_zero    <= RST_CTRL0;
			cfg_q.control_seq_one     <= RST_CTRL1;
		end else if (wr_en) begin
			case (idx)
				REG_FLAG:     cfg_q.flag_byte           <= pwdata[7:0];
				REG_ESC:      cfg_q.esc_char            <= pwdata[7:0];
				REG_ESC_FLAG: cfg_q.escaped_flag_code   <= pwdata[7:0];
				REG_ESC_ESC:  cfg_q.escaped_escape_code <= pwdata[7:0];
				REG_ADDR:     cfg_q.address_byte        <= pwdata[7:0];
				REG_CTRL0:    cfg_q.control_seq_zero    <= pwdata[7:0];
				REG_CTRL1:    cfg_q.control_seq_one     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FLAG:     rd_byte = cfg_q.flag_byte;
			REG_ESC:      rd_byte = cfg_q.esc_char;
			REG_ESC_FLAG: rd_byte = cfg_q.escaped_flag_code;
			REG_ESC_ESC:  rd_byte = cfg_q.escaped_escape_code;
			REG_ADDR:     rd_byte = cfg_q.address_byte;
			REG_CTRL0:    rd_byte = cfg_q.control_seq_zero;
			REG_CTRL1:    rd_byte = cfg_q.control_seq_one;
			default:      rd_byte = 8'd0;
		endcase
	end

	assign prdata = {{(DATA_W-8){1'b0}}, rd_byte};
	assign cfg    = cfg_q;

endmodule

[hw/rtl/sfb_front.sv]
// ----------------------------------------------------------------------------
// sfb_front
// Takes payload requests, keeps the running XOR check and flags bytes that
// need an escape.
// ----------------------------------------------------------------------------
module sfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  sfb_pkg::in_item_t in_item,
	input  sfb_pkg::cfg_t     cfg,
	output sfb_pkg::job_t     job
);
	import sfb_pkg::*;

	logic [7:0] parity_q;
	logic [7:0] parity_base;
	logic [7:0] parity_new;

	// a new frame starts its check from zero
	assign parity_base = in_item.first_byte ? 8'd0 : parity_q;
	assign parity_new  = parity_base ^ in_item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 8'd0;
		end else if (accept) begin
			parity_q <= in_item.last_byte ? 8'd0 : parity_new;
		end
	end

	// flag wins when flag and escape values coincide
	always_comb begin
		job.data_byte    = in_item.data_byte;
		job.first_byte   = in_item.first_byte;
		job.last_byte    = in_item.last_byte;
		job.seq_bit      = in_item.seq_bit;
		job.data_is_flag = (in_item.data_byte == cfg.flag_byte);
		job.data_is_esc  = (in_item.data_byte == cfg.esc_char);
		job.bcc          = parity_new;
		job.bcc_is_flag  = (parity_new == cfg.flag_byte);
		job.bcc_is_esc   = (parity_new == cfg.esc_char);
	end

endmodule

[hw/rtl/sfb_queue.sv]
// ----------------------------------------------------------------------------
// sfb_queue
// Small request queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module sfb_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfb_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output sfb_pkg::job_t rd_job,
	output logic          empty
);
	import sfb_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slots_q [DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + IW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + IW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[hw/rtl/sfb_back.sv]
// ----------------------------------------------------------------------------
// sfb_back
// Byte sequencer: walks header, stuffed payload, check and closing flag of
// the head request into the output register, one byte a cycle while it has room.
// ----------------------------------------------------------------------------
module sfb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sfb_pkg::cfg_t       cfg,
	input  sfb_pkg::job_t       job,
	input  logic                job_valid,
	output logic                job_done,
	output sfb_pkg::out_item_t  out_item,
	output logic                empty,
	input  logic                pop,
	output sfb_pkg::bk_status_t status
);
	import sfb_pkg::*;

	step_t      step_q;
	step_t      cur_step;
	step_t      next_step;
	logic       emit;
	logic       done;
	logic [7:0] byte_nxt;
	logic [7:0] ctrl;
	logic       out_valid_q;
	out_item_t  out_q;

	assign emit = job_valid && (!out_valid_q || pop);
	assign ctrl = job.seq_bit ? cfg.control_seq_one : cfg.control_seq_zero;

	always_comb begin
		if (step_q == ST_START) begin
			cur_step = job.first_byte ? ST_FLAG_OPEN : ST_DATA;
		end else begin
			cur_step = step_q;
		end
	end

	always_comb begin
		byte_nxt  = cfg.flag_byte;
		next_step = ST_START;
		done      = 1'b0;
		case (cur_step)
			ST_FLAG_OPEN: begin
				byte_nxt  = cfg.flag_byte;
				next_step = ST_ADDR;
			end
			ST_ADDR: begin
				byte_nxt  = cfg.address_byte;
				next_step = ST_CTRL;
			end
			ST_CTRL: begin
				byte_nxt  = ctrl;
				next_step = ST_HCS;
			end
			ST_HCS: begin
				byte_nxt  = cfg.address_byte ^ ctrl;
				next_step = ST_DATA;
			end
			ST_DATA: begin
				if (job.data_is_flag || job.data_is_esc) begin
					byte_nxt  = cfg.esc_char;
					next_step = ST_DATA_CODE;
				end else begin
					byte_nxt  = job.data_byte;
					next_step = job.last_byte ? ST_BCC : ST_START;
					done      = !job.last_byte;
				end
			end
			ST_DATA_CODE: begin
				byte_nxt  = job.data_is_flag ? cfg.escaped_flag_code : cfg.escaped_escape_code;
				next_step = job.last_byte ? ST_BCC : ST_START;
				done      = !job.last_byte;
			end
			ST_BCC: begin
				if (job.bcc_is_flag || job.bcc_is_esc) begin
					byte_nxt  = cfg.esc_char;
					next_step = ST_BCC_CODE;
				end else begin
					byte_nxt  = job.bcc;
					next_step = ST_FLAG_CLOSE;
				end
			end
			ST_BCC_CODE: begin
				byte_nxt  = job.bcc_is_flag ? cfg.escaped_flag_code : cfg.escaped_escape_code;
				next_step = ST_FLAG_CLOSE;
			end
			ST_FLAG_CLOSE: begin
				byte_nxt  = cfg.flag_byte;
				next_step = ST_START;
				done      = 1'b1;
			end
			default: begin
				byte_nxt  = cfg.flag_byte;
				next_step = ST_START;
				done      = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_START;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				step_q <= next_step;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte   <= byte_nxt;
			out_q.end_of_run <= done;
		end
	end

	assign job_done       = emit && done;
	assign out_item       = out_q;
	assign empty          = !out_valid_q;
	assign status.emit    = emit;
	assign status.mid_job = (step_q != ST_START);

endmodule

[hw/rtl/stuffed_frame_builder_top.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_builder_top
// Byte-stuffing frame builder with an XOR block check.
// ----------------------------------------------------------------------------
// Each payload request yields 1 to 9 framed bytes (header on a first byte,
// escape pairs for flag or escape values, check and closing flag on a last
// byte); a one-byte frame with both the byte and the check escaped gives
// nine. The back-end sequencer emits one result byte per cycle while its
// output register has room, and keeps an item at the queue head until all
// of its bytes are out. Input requests are taken every cycle until the
// QUEUE_DEPTH entry queue in front of the sequencer fills; the output
// register lets a new byte be produced in the same cycle the previous one
// is popped. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stuffed_frame_builder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  sfb_pkg::in_item_t          in_item,
	output logic                       empty,
	input  logic                       pop,
	output sfb_pkg::out_item_t         out_item,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfb_pkg::ADDR_W-1:0] paddr,
	input  logic [sfb_pkg::DATA_W-1:0] pwdata,
	output logic [sfb_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import sfb_pkg::*;

	cfg_t       cfg;
	job_t       fr_job;
	job_t       q_job;
	logic       in_acc;
	logic       q_empty;
	logic       q_pop;
	bk_status_t bk_status;

	assign in_acc = push && !full;

	sfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_acc),
		.in_item (in_item),
		.cfg     (cfg),
		.job     (fr_job)
	);

	sfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_acc),
		.wr_job (fr_job),
		.full   (full),
		.pop    (q_pop),
		.rd_job (q_job),
		.empty  (q_empty)
	);

	sfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (q_job),
		.job_valid (!q_empty),
		.job_done  (q_pop),
		.out_item  (out_item),
		.empty     (empty),
		.pop       (pop),
		.status    (bk_status)
	);

	// a request in flight must still sit at the queue head
	`ASSERT_IMPLY(a_mid_job_has_req, bk_status.mid_job, !q_empty, "sequencer mid-request with empty queue")
	`ASSERT_IMPLY(a_emit_has_req, bk_status.emit, !q_empty, "byte emitted with no queued request")
	`ASSERT_NEXT(a_push_lands, in_acc, !q_empty, "accepted request missing from queue")

endmodule

[sim/stuffed_frame_builder_top_test.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_builder_top_test
// Self-checking bench for the stuffed frame builder. Payload requests go in
// through the push side and the framed byte stream is popped and compared
// byte by byte against a local predictor of header, stuffing, XOR check and
// closing flag. Registers are set over the APB port between traffic phases.
// ----------------------------------------------------------------------------
module stuffed_frame_builder_top_test;
	import sfb_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 300;
	localparam int CALM_ITEMS    = 80;
	localparam int ITEMS_PER_CFG = 100;
	localparam int HOLD_CYCLES   = 200;
	localparam int FLOOD_ITEMS   = 30;
	localparam int NUM_REGS      = 7;
	// decodes to no register; writes there must be dropped
	localparam logic [2:0] UNUSED_REG = 3'd7;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              push    = 1'b0;
	logic              full;
	in_item_t          in_item = '0;
	logic              empty;
	logic              pop     = 1'b0;
	out_item_t         out_item;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	cfg_t       cfg_shadow;
	logic [7:0] payload_xor;
	out_item_t  framed_q[$];
	out_item_t  want;
	int         errors      = 0;
	int         cycle_count = 0;
	int         items_sent  = 0;
	bit         gaps_on     = 1'b1;
	int         hold_left   = 0;
	int         pop_stall   = 0;

	stuffed_frame_builder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.empty   (empty),
		.pop     (pop),
		.out_item(out_item),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------- frame predictor ----------------

	function automatic void emit_byte(logic [7:0] b);
		out_item_t r;
		r.out_byte   = b;
		r.end_of_run = 1'b0;
		framed_q.push_back(r);
	endfunction

	function automatic void emit_stuffed(logic [7:0] b);
		// flag wins when flag and escape share a value
		if (b == cfg_shadow.flag_byte) begin
			emit_byte(cfg_shadow.esc_char);
			emit_byte(cfg_shadow.escaped_flag_code);
		end else if (b == cfg_shadow.esc_char) begin
			emit_byte(cfg_shadow.esc_char);
			emit_byte(cfg_shadow.escaped_escape_code);
		end else begin
			emit_byte(b);
		end
	endfunction

	function automatic void frame_bytes_for(in_item_t it);
		logic [7:0] ctrl;
		if (it.first_byte) begin
			ctrl = it.seq_bit ? cfg_shadow.control_seq_one : cfg_shadow.control_seq_zero;
			payload_xor = '0;
			emit_byte(cfg_shadow.flag_byte);
			emit_byte(cfg_shadow.address_byte);
			emit_byte(ctrl);
			emit_byte(cfg_shadow.address_byte ^ ctrl);
		end
		emit_stuffed(it.data_byte);
		payload_xor ^= it.data_byte;
		if (it.last_byte) begin
			emit_stuffed(payload_xor);
			emit_byte(cfg_shadow.flag_byte);
			payload_xor = '0;
		end
		framed_q[framed_q.size() - 1].end_of_run = 1'b1;
	endfunction

	function automatic logic [7:0] reg_shadow(logic [2:0] idx);
		case (idx)
			REG_FLAG:     return cfg_shadow.flag_byte;
			REG_ESC:      return cfg_shadow.esc_char;
			REG_ESC_FLAG: return cfg_shadow.escaped_flag_code;
			REG_ESC_ESC:  return cfg_shadow.escaped_escape_code;
			REG_ADDR:     return cfg_shadow.address_byte;
			REG_CTRL0:    return cfg_shadow.control_seq_zero;
			REG_CTRL1:    return cfg_shadow.control_seq_one;
			default:      return 8'h00;
		endcase
	endfunction

	// ---------------- result side ----------------

	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left--;
		end else if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			pop_stall = $urandom_range(1, 6) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && !empty && pop) begin
			if (framed_q.size() == 0) begin
				$display("%0t: unexpected byte %02h end_of_run %0b", $time,
					out_item.out_byte, out_item.end_of_run);
				errors++;
			end else begin
				want = framed_q.pop_front();
				if (out_item.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h", $time,
						want.out_byte, out_item.out_byte);
					errors++;
				end
				if (out_item.end_of_run !== want.end_of_run) begin
					$display("%0t: end_of_run expected %0b got %0b", $time,
						want.end_of_run, out_item.end_of_run);
					errors++;
				end
			end
		end
	end

	// ---------------- request side ----------------

	function automatic in_item_t make_item(logic [7:0] d, logic f, logic l, logic s);
		in_item_t it;
		it.data_byte  = d;
		it.first_byte = f;
		it.last_byte  = l;
		it.seq_bit    = s;
		return it;
	endfunction

	task automatic send_byte(in_item_t it);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push    <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		frame_bytes_for(it);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (framed_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------- register port ----------------

	task automatic write_register(logic [2:0] idx, logic [7:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FLAG:     cfg_shadow.flag_byte           = val;
			REG_ESC:      cfg_shadow.esc_char            = val;
			REG_ESC_FLAG: cfg_shadow.escaped_flag_code   = val;
			REG_ESC_ESC:  cfg_shadow.escaped_escape_code = val;
			REG_ADDR:     cfg_shadow.address_byte        = val;
			REG_CTRL0:    cfg_shadow.control_seq_zero    = val;
			REG_CTRL1:    cfg_shadow.control_seq_one     = val;
			default:      ;
		endcase
	endtask

	task automatic check_registers();
		logic [2:0] idx;
		for (int k = 0; k < NUM_REGS; k++) begin
			idx = 3'(k);
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= ADDR_W'({idx, 2'b00});
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata[7:0] !== reg_shadow(idx)) begin
				$display("%0t: register %0d expected %02h got %02h", $time, idx,
					reg_shadow(idx), prdata[7:0]);
				errors++;
			end
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic write_all(logic [7:0] val);
		write_register(REG_FLAG, val);
		write_register(REG_ESC, val);
		write_register(REG_ESC_FLAG, val);
		write_register(REG_ESC_ESC, val);
		write_register(REG_ADDR, val);
		write_register(REG_CTRL0, val);
		write_register(REG_CTRL1, val);
	endtask

	task automatic random_config();
		logic [7:0] f;
		f = 8'($urandom_range(0, 255));
		write_register(REG_FLAG, f);
		write_register(REG_ESC, ($urandom_range(0, 7) == 0) ? f : 8'($urandom_range(0, 255)));
		write_register(REG_ESC_FLAG, 8'($urandom_range(0, 255)));
		write_register(REG_ESC_ESC, 8'($urandom_range(0, 255)));
		write_register(REG_ADDR, 8'($urandom_range(0, 255)));
		write_register(REG_CTRL0, 8'($urandom_range(0, 255)));
		write_register(REG_CTRL1, 8'($urandom_range(0, 255)));
	endtask

	// payload biased toward the values that need stuffing
	function automatic logic [7:0] pick_payload();
		case ($urandom_range(0, 7))
			0:       return cfg_shadow.flag_byte;
			1:       return cfg_shadow.esc_char;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_frame();
		int         len;
		bit         broken;
		in_item_t   it;
		logic [7:0] hit;
		broken = ($urandom_range(0, 9) == 0);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			it.data_byte = pick_payload();
			it.seq_bit   = 1'($urandom_range(0, 1));
			if (broken) begin
				it.first_byte = 1'($urandom_range(0, 1));
				it.last_byte  = 1'($urandom_range(0, 1));
			end else begin
				it.first_byte = (i == 0);
				it.last_byte  = (i == len - 1);
				// steer the check byte onto flag or escape now and then
				if (it.last_byte && $urandom_range(0, 5) == 0) begin
					hit = $urandom_range(0, 1) ? cfg_shadow.flag_byte : cfg_shadow.esc_char;
					it.data_byte = (it.first_byte ? 8'h00 : payload_xor) ^ hit;
				end
			end
			send_byte(it);
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_register_defaults();
		check_registers();
	endtask

	task automatic test_directed_frames();
		send_byte(make_item(8'h00, 1'b1, 1'b1, 1'b0));
		send_byte(make_item(8'hFF, 1'b1, 1'b1, 1'b1));
		send_byte(make_item(RST_FLAG, 1'b1, 1'b0, 1'b0));
		send_byte(make_item(RST_ESC, 1'b0, 1'b0, 1'b1));
		send_byte(make_item(8'h55, 1'b0, 1'b1, 1'b0));
		// one-byte frames where both byte and check need escapes
		send_byte(make_item(RST_ESC, 1'b1, 1'b1, 1'b1));
		send_byte(make_item(RST_FLAG, 1'b1, 1'b1, 1'b0));
		// bytes with no open frame
		send_byte(make_item(8'hAA, 1'b0, 1'b0, 1'b0));
		send_byte(make_item(8'h01, 1'b0, 1'b1, 1'b1));
		// check byte lands on the flag value
		send_byte(make_item(8'h01, 1'b1, 1'b0, 1'b0));
		send_byte(make_item(8'h7F, 1'b0, 1'b1, 1'b0));
		// new frame opened over an unfinished one
		send_byte(make_item(8'h10, 1'b1, 1'b0, 1'b1));
		send_byte(make_item(8'h20, 1'b1, 1'b1, 1'b0));
		drain_results();
	endtask

	task automatic test_register_extremes();
		write_all(8'h00);
		check_registers();
		send_byte(make_item(8'h00, 1'b1, 1'b0, 1'b1));
		send_byte(make_item(8'hFF, 1'b0, 1'b1, 1'b0));
		drain_results();
		write_all(8'hFF);
		check_registers();
		send_byte(make_item(8'hFF, 1'b1, 1'b1, 1'b1));
		send_byte(make_item(8'h00, 1'b1, 1'b0, 1'b0));
		send_byte(make_item(8'hFF, 1'b0, 1'b1, 1'b0));
		drain_results();
		// flag and escape on the same value
		write_register(REG_FLAG, 8'h55);
		write_register(REG_ESC, 8'h55);
		write_register(REG_ESC_FLAG, 8'hAA);
		write_register(REG_ESC_ESC, 8'h33);
		send_byte(make_item(8'h55, 1'b1, 1'b1, 1'b0));
		drain_results();
	endtask

	task automatic test_unused_register();
		write_register(UNUSED_REG, 8'h99);
		check_registers();
		send_byte(make_item(8'h99, 1'b1, 1'b1, 1'b1));
		drain_results();
	endtask

	task automatic test_backpressure();
		random_config();
		gaps_on = 1'b0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		repeat (FLOOD_ITEMS) send_byte(make_item(pick_payload(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
		drain_results();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int target;
		int cfg_mark;
		target   = items_sent + RANDOM_ITEMS;
		cfg_mark = items_sent;
		while (items_sent < target) begin
			if (items_sent - cfg_mark >= ITEMS_PER_CFG) begin
				drain_results();
				random_config();
				check_registers();
				cfg_mark = items_sent;
			end
			if (target - items_sent <= CALM_ITEMS)
				gaps_on = 1'b0;
			send_random_frame();
		end
	endtask

	initial begin
		cfg_shadow.flag_byte           = RST_FLAG;
		cfg_shadow.esc_char            = RST_ESC;
		cfg_shadow.escaped_flag_code   = RST_ESC_FLAG;
		cfg_shadow.escaped_escape_code = RST_ESC_ESC;
		cfg_shadow.address_byte        = RST_ADDR;
		cfg_shadow.control_seq_zero    = RST_CTRL0;
		cfg_shadow.control_seq_one     = RST_CTRL1;
		payload_xor = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_register_defaults();
		test_directed_frames();
		test_register_extremes();
		test_unused_register();
		test_backpressure();
		test_random_traffic();

		drain_results();
		if (errors == 0 && framed_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sfb_pkg.sv
hw/rtl/sfb_regs.sv
hw/rtl/sfb_front.sv
hw/rtl/sfb_queue.sv
hw/rtl/sfb_back.sv
hw/rtl/stuffed_frame_builder_top.sv
sim/stuffed_frame_builder_top_test.sv
